### rtl/rgb_ycbcr_color_converter_assert.svh
// Assertion macros shared by the color converter RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef RGB_YCBCR_COLOR_CONVERTER_ASSERT_SVH
`define RGB_YCBCR_COLOR_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define YCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a sequence consequent (may carry a fixed delay).
`define YCC_ASSERT_SEQ(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

### rtl/ycc_pkg.sv
// Package for the RGB/YCbCr converter: widths, fixed-point coefficients,
// stage types. No dependencies.
`timescale 1ns / 1ps

package ycc_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int PIX_W  = 8;
  localparam int OPND_W = PIX_W + 1;
  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int PROD_W = COEF_W + OPND_W;
  localparam int ACC_W  = COEF_FRAC_BITS + 11;
  localparam int NUM_CH = 3;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [PIX_W-1:0]         pix_t;

  typedef enum logic {
    DIR_TO_YCC = 1'b0,
    DIR_TO_RGB = 1'b1
  } ycc_dir_e;

  // Control word traveling beside the data through every stage.
  typedef struct packed {
    logic     valid;
    ycc_dir_e dir;
    pix_t     alpha;
  } ycc_ctl_t;

  typedef coef_t coef_mat_t [NUM_CH][NUM_CH];
  typedef acc_t  acc_vec_t  [NUM_CH];

  // Nearest fixed-point value of a coefficient given in millionths, ties up.
  function automatic longint qcoef(longint micro);
    return ((micro << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  endfunction

  localparam coef_t ONE_Q = coef_t'(longint'(1) << COEF_FRAC_BITS);

  // Rows are output channels, columns the three operands.
  localparam coef_mat_t COEF_FWD = '{
    '{ coef_t'(qcoef(299000)),  coef_t'(qcoef(587000)),  coef_t'(qcoef(114000))},
    '{-coef_t'(qcoef(168000)), -coef_t'(qcoef(331000)),  coef_t'(qcoef(500000))},
    '{ coef_t'(qcoef(500000)), -coef_t'(qcoef(418700)), -coef_t'(qcoef(81300))}
  };

  localparam coef_mat_t COEF_INV = '{
    '{ONE_Q,  coef_t'(0),               coef_t'(qcoef(1402000))},
    '{ONE_Q, -coef_t'(qcoef(344136)), -coef_t'(qcoef(714136))},
    '{ONE_Q,  coef_t'(qcoef(1772000)),  coef_t'(0)}
  };

  localparam acc_t HALF_Q   = acc_t'(longint'(1) << (COEF_FRAC_BITS - 1));
  localparam acc_t BIAS_128 = acc_t'(longint'(128) << COEF_FRAC_BITS);

  // Rounding half LSB, folded together with the chroma bias on the forward Cb/Cr channels.
  localparam acc_vec_t OFF_FWD = '{HALF_Q, HALF_Q + BIAS_128, HALF_Q + BIAS_128};
  localparam acc_vec_t OFF_INV = '{HALF_Q, HALF_Q, HALF_Q};

endpackage

### rtl/rgb_ycbcr_color_converter.sv
// RGB <-> full-range YCbCr converter, top level; uses ycc_pkg, ycc_prep,
// ycc_mult, ycc_rnd and the assertion macro header.
// Each word passes the registered operand, product, sum and round/saturate
// stages; valid_o and the results are taken from the last of them.
// Throughput: one word per clock; busy is never raised, nothing stalls.
// Reset clears all stage valid bits and sets direction to RGB -> YCbCr.
`timescale 1ns / 1ps

`include "rgb_ycbcr_color_converter_assert.svh"

module rgb_ycbcr_color_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style config port: register 0 (direction) at byte address 0
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel in
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_first_i,
  input  logic [7:0]  in_second_i,
  input  logic [7:0]  in_third_i,
  input  logic [7:0]  in_alpha_i,
  // pixel out, one cycle strobe
  output logic        valid_o,
  output logic [7:0]  out_first_o,
  output logic [7:0]  out_second_o,
  output logic [7:0]  out_third_o,
  output logic [7:0]  out_alpha_o
);
  import ycc_pkg::*;

  localparam logic REG_DIRECTION = 1'b0;  // word index of the only register

  ycc_dir_e dir_q;
  logic     cfg_wr;
  logic     accept;

  opnd_t    ops    [NUM_CH];
  ycc_ctl_t prep_ctl;
  prod_t    prod   [NUM_CH][NUM_CH];
  ycc_ctl_t mult_ctl;
  pix_t     pix    [NUM_CH];
  ycc_ctl_t out_ctl;

  // ---------------------------------------------------------------
  // Configuration: zero-wait APB, word index is paddr[2]. The low
  // address bits are ignored; writes beyond register 0 drop.
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_TO_YCC;
    end else if (cfg_wr) begin
      dir_q <= ycc_dir_e'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DIRECTION) begin
      prdata[0] = dir_q;
    end
  end

  // ---------------------------------------------------------------
  // Datapath: operands -> products -> sums -> round/saturate.
  // Direction is sampled with each word and rides along with it,
  // so words in flight keep the mode they entered with.
  // ---------------------------------------------------------------
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ycc_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .dir_i    (dir_q),
    .first_i  (in_first_i),
    .second_i (in_second_i),
    .third_i  (in_third_i),
    .alpha_i  (in_alpha_i),
    .ops_o    (ops),
    .ctl_o    (prep_ctl)
  );

  ycc_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ops_i  (ops),
    .ctl_i  (prep_ctl),
    .prod_o (prod),
    .ctl_o  (mult_ctl)
  );

  ycc_rnd u_rnd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prod_i (prod),
    .ctl_i  (mult_ctl),
    .pix_o  (pix),
    .ctl_o  (out_ctl)
  );

  // Results are registered in the last stage; hand them straight out.
  assign valid_o      = out_ctl.valid;
  assign out_first_o  = pix[0];
  assign out_second_o = pix[1];
  assign out_third_o  = pix[2];
  assign out_alpha_o  = out_ctl.alpha;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `YCC_ASSERT_SEQ(a_word_emerges, accept, ##4 valid_o, "accepted word did not emerge after 4 cycles")
  `YCC_ASSERT_NOW(a_no_phantom, valid_o, $past(accept, 4), "result strobe without an accepted word")
  `YCC_ASSERT_NOW(a_alpha_pass, valid_o, out_alpha_o == $past(in_alpha_i, 4), "alpha corrupted in pipe")

endmodule

### rtl/ycc_prep.sv
// Operand stage: register pixel components as signed operands per direction.
// Depends on ycc_pkg.
`timescale 1ns / 1ps

module ycc_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ycc_pkg::ycc_dir_e dir_i,
  input  ycc_pkg::pix_t     first_i,
  input  ycc_pkg::pix_t     second_i,
  input  ycc_pkg::pix_t     third_i,
  input  ycc_pkg::pix_t     alpha_i,
  output ycc_pkg::opnd_t    ops_o [ycc_pkg::NUM_CH],
  output ycc_pkg::ycc_ctl_t ctl_o
);
  import ycc_pkg::*;

  localparam opnd_t CHROMA_MID = opnd_t'(128);

  opnd_t    ops_d [NUM_CH];
  opnd_t    ops_q [NUM_CH];
  logic     valid_q;
  ycc_dir_e dir_q;
  pix_t     alpha_q;

  always_comb begin
    ops_d[0] = opnd_t'({1'b0, first_i});
    ops_d[1] = opnd_t'({1'b0, second_i});
    ops_d[2] = opnd_t'({1'b0, third_i});
    // center chroma around zero on the way back to RGB
    if (dir_i == DIR_TO_RGB) begin
      ops_d[1] = ops_d[1] - CHROMA_MID;
      ops_d[2] = ops_d[2] - CHROMA_MID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ops_q   <= ops_d;
    dir_q   <= dir_i;
    alpha_q <= alpha_i;
  end

  assign ops_o = ops_q;
  assign ctl_o = '{valid: valid_q, dir: dir_q, alpha: alpha_q};

endmodule

### rtl/ycc_mult.sv
// Product stage: nine signed constant multiplies, one register each.
// Depends on ycc_pkg.
`timescale 1ns / 1ps

module ycc_mult (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ycc_pkg::opnd_t    ops_i  [ycc_pkg::NUM_CH],
  input  ycc_pkg::ycc_ctl_t ctl_i,
  output ycc_pkg::prod_t    prod_o [ycc_pkg::NUM_CH][ycc_pkg::NUM_CH],
  output ycc_pkg::ycc_ctl_t ctl_o
);
  import ycc_pkg::*;

  prod_t    prod_d [NUM_CH][NUM_CH];
  prod_t    prod_q [NUM_CH][NUM_CH];
  ycc_ctl_t ctl_q;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      for (int j = 0; j < NUM_CH; j++) begin
        prod_d[i][j] = prod_t'(ops_i[j]) *
                       prod_t'((ctl_i.dir == DIR_TO_RGB) ? COEF_INV[i][j] : COEF_FWD[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;
  assign ctl_o  = ctl_q;

endmodule

### rtl/ycc_rnd.sv
// Sum stage and round/saturate stage driving the result registers.
// Depends on ycc_pkg.
`timescale 1ns / 1ps

module ycc_rnd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ycc_pkg::prod_t    prod_i [ycc_pkg::NUM_CH][ycc_pkg::NUM_CH],
  input  ycc_pkg::ycc_ctl_t ctl_i,
  output ycc_pkg::pix_t     pix_o  [ycc_pkg::NUM_CH],
  output ycc_pkg::ycc_ctl_t ctl_o
);
  import ycc_pkg::*;

  acc_t     acc_d [NUM_CH];
  acc_t     acc_q [NUM_CH];
  ycc_ctl_t sum_ctl_q;
  pix_t     pix_d [NUM_CH];
  pix_t     pix_q [NUM_CH];
  ycc_ctl_t out_ctl_q;

  // Sum three products plus the rounding half and, for the forward chroma channels, the bias.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      acc_d[i] = acc_t'(prod_i[i][0]) + acc_t'(prod_i[i][1]) + acc_t'(prod_i[i][2]) +
                 ((ctl_i.dir == DIR_TO_RGB) ? OFF_INV[i] : OFF_FWD[i]);
    end
  end

  // Floor by dropping fraction bits, then clamp to the pixel range.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      priority if (acc_q[i][ACC_W-1]) begin
        pix_d[i] = '0;
      end else if (|acc_q[i][ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
        pix_d[i] = '1;
      end else begin
        pix_d[i] = acc_q[i][COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_ctl_q <= '0;
      out_ctl_q <= '0;
    end else begin
      sum_ctl_q <= ctl_i;
      out_ctl_q <= sum_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    pix_q <= pix_d;
  end

  assign pix_o = pix_q;
  assign ctl_o = out_ctl_q;

endmodule
